/* sv/dqk_pkg.sv */
`default_nettype none
package dqk_pkg;
  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 16;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  typedef logic [3:0] func_t;
  localparam func_t FN_PUSH_FRONT = 4'd0;
  localparam func_t FN_PUSH_BACK  = 4'd1;
  localparam func_t FN_POP_FRONT  = 4'd2;
  localparam func_t FN_POP_BACK   = 4'd3;
  localparam func_t FN_DELETE     = 4'd4;
  localparam func_t FN_TRIM_FRONT = 4'd5;
  localparam func_t FN_TRIM_BACK  = 4'd6;
  localparam func_t FN_CLEAR      = 4'd7;
  localparam func_t FN_SWAP       = 4'd8;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_EMPTY    = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

  // datapath commands, one per step of the sequencer
  typedef enum logic [3:0] {
    CMD_NONE   = 4'd0,
    CMD_LOAD   = 4'd1,  // latch item, reset walk index
    CMD_SIMPLE = 4'd2,  // push, pop, clear and other operations that need no walk
    CMD_RD     = 4'd3,  // issue read at walk index
    CMD_SCAN   = 4'd4,  // consume read data for search, advance
    CMD_SHIFT  = 4'd5,  // write slot(i) from read data of slot(i+1)
    CMD_FIN    = 4'd6,  // finish search op
    CMD_SWAP1  = 4'd7,  // write back side read data to front
    CMD_SWAP2  = 4'd8   // write front read data to back
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic out_take;
  } ctl_t;

  typedef struct packed {
    func_t func;        // function of the item in progress
    func_t in_func;     // function of the item waiting at the input
    logic  walk_done;   // walk index reached occupancy
    logic  found;       // key hit in last scanned entry
    logic  shift_done;  // no more entries to move
    logic  out_full;
  } sts_t;
endpackage
`default_nettype wire

/* sv/dqk_if.sv */
`default_nettype none
interface dqk_in_if;
  logic              valid;
  logic              ready;
  logic [3:0]        func;
  logic signed [15:0] operand;
  modport source (output valid, func, operand, input ready);
  modport sink (input valid, func, operand, output ready);
endinterface

interface dqk_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [15:0] result_value;
  logic [4:0]         entry_count;
  modport source (output valid, status, result_value, entry_count, input ready);
  modport sink (input valid, status, result_value, entry_count, output ready);
endinterface
`default_nettype wire

/* sv/dqk_ctrl.sv */
`default_nettype none
module dqk_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire dqk_pkg::sts_t sts,
  output dqk_pkg::ctl_t ctl
);
  import dqk_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD    = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_SHRD  = 7'b0001000,
    S_SHWR  = 7'b0010000,
    S_SWAP  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE) && !sts.out_full;

  always_comb begin
    state_next   = state;
    ctl.cmd      = CMD_NONE;
    ctl.out_take = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          ctl.cmd = CMD_LOAD;
          case (sts.in_func)
            FN_DELETE, FN_TRIM_FRONT, FN_TRIM_BACK, FN_SWAP: state_next = S_RD;
            default: begin
              ctl.cmd = CMD_SIMPLE;
            end
          endcase
        end
      end
      S_RD: begin
        ctl.cmd = CMD_RD;
        if (sts.func == FN_SWAP) state_next = S_SWAP;
        else if (sts.walk_done) state_next = S_FIN;
        else state_next = S_SCAN;
      end
      S_SCAN: begin
        ctl.cmd = CMD_SCAN;
        if (sts.func == FN_DELETE && sts.found) state_next = S_SHRD;
        else state_next = S_RD;
      end
      S_SHRD: begin
        ctl.cmd = CMD_RD;
        state_next = sts.shift_done ? S_FIN : S_SHWR;
      end
      S_SHWR: begin
        ctl.cmd = CMD_SHIFT;
        state_next = S_SHRD;
      end
      S_SWAP: begin
        ctl.cmd = CMD_SWAP1;
        state_next = S_FIN;
      end
      S_FIN: begin
        ctl.cmd = (sts.func == FN_SWAP) ? CMD_SWAP2 : CMD_FIN;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (ctl.cmd == CMD_LOAD) |-> (state == S_IDLE) && in_ready) else $error("load outside idle");
  a_fin_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> (state == S_IDLE)) else $error("fin not followed by idle");
  a_shwr_from_shrd: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHWR) |-> $past(state) == S_SHRD) else $error("bad shift order");
endmodule
`default_nettype wire

/* sv/dqk_dp.sv */
`default_nettype none
module dqk_dp (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [3:0] in_func,
  input  wire logic signed [15:0] in_operand,
  input  wire dqk_pkg::ctl_t ctl,
  output dqk_pkg::sts_t sts,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [1:0] out_status,
  output logic signed [15:0] out_value,
  output logic [4:0] out_count
);
  import dqk_pkg::*;

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] rdata;
  logic [VALUE_WIDTH-1:0] key, best, swap_hold;
  logic [IDX_W-1:0] front;
  logic [CNT_W-1:0] occ, walk, best_i;
  func_t func;
  logic  found;

  // slot arithmetic wraps modulo CAPACITY
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] f,
                                               input logic [CNT_W-1:0] i);
    logic [CNT_W+IDX_W:0] s;
    s = {{(CNT_W+1){1'b0}}, f} + {{(IDX_W+1){1'b0}}, i};
    return IDX_W'(s % CAPACITY);
  endfunction

  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [IDX_W-1:0]  back_slot;
  logic [VALUE_WIDTH-1:0] opv;

  assign opv       = VALUE_WIDTH'(in_operand);
  assign back_slot = slot_of(front, occ - CNT_W'(1));
  assign raddr = (ctl.cmd == CMD_RD && func == FN_SWAP && walk == '0) ? back_slot
               : slot_of(front, walk);

  assign sts.func       = func;
  assign sts.in_func    = in_func;
  assign sts.walk_done  = (walk >= occ);
  assign sts.found      = (rdata == key);
  assign sts.shift_done = (walk >= occ);
  assign sts.out_full   = out_valid;

  always_comb begin
    we = 1'b0; waddr = slot_of(front, walk); wdata = rdata;
    case (ctl.cmd)
      CMD_SIMPLE: begin
        if (in_func == FN_PUSH_FRONT && occ < CNT_W'(CAPACITY)) begin
          we = 1'b1; waddr = front - IDX_W'(1); wdata = opv;
        end else if (in_func == FN_PUSH_BACK && occ < CNT_W'(CAPACITY)) begin
          we = 1'b1; waddr = slot_of(front, occ); wdata = opv;
        end
      end
      CMD_SHIFT: begin
        we = 1'b1; waddr = slot_of(front, walk - CNT_W'(2)); wdata = rdata;
      end
      CMD_SWAP1: begin
        we = 1'b1; waddr = front; wdata = rdata;
      end
      CMD_SWAP2: begin
        we = 1'b1; waddr = back_slot; wdata = swap_hold;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0; occ <= '0; out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (ctl.cmd)
        CMD_LOAD, CMD_SIMPLE: begin
          func <= in_func; key <= opv; walk <= '0; found <= 1'b0; best_i <= '0;
          if (ctl.cmd == CMD_SIMPLE) begin
            out_valid <= 1'b1; out_status <= ST_OK; out_value <= '0;
            out_count <= 5'(occ);
            case (in_func)
              FN_PUSH_FRONT, FN_PUSH_BACK: begin
                if (occ >= CNT_W'(CAPACITY)) out_status <= ST_FULL;
                else begin
                  if (in_func == FN_PUSH_FRONT) front <= front - IDX_W'(1);
                  occ <= occ + CNT_W'(1); out_count <= 5'(occ + CNT_W'(1));
                end
              end
              FN_POP_FRONT, FN_POP_BACK: begin
                if (occ == '0) out_status <= ST_EMPTY;
                else begin
                  out_value <= 16'($signed(in_func == FN_POP_FRONT ? mem[front]
                                                                  : mem[back_slot]));
                  if (in_func == FN_POP_FRONT) front <= front + IDX_W'(1);
                  occ <= occ - CNT_W'(1); out_count <= 5'(occ - CNT_W'(1));
                end
              end
              FN_CLEAR: begin
                occ <= '0; out_count <= '0;
              end
              default: ;
            endcase
          end
        end
        CMD_RD: walk <= walk + CNT_W'(1);
        CMD_SCAN: begin
          if (func == FN_DELETE) begin
            if (rdata == key) found <= 1'b1;
          end else if (walk == CNT_W'(1) || $signed(rdata) < $signed(best)) begin
            best <= rdata; best_i <= walk - CNT_W'(1);
          end
          if (func == FN_DELETE && rdata == key) best <= rdata;
        end
        CMD_SWAP1: begin
          swap_hold <= mem[front];
        end
        CMD_FIN, CMD_SWAP2: begin
          out_valid <= 1'b1; out_value <= '0; out_status <= ST_OK;
          out_count <= 5'(occ);
          case (func)
            FN_DELETE: begin
              if (!found) out_status <= ST_NOTFOUND;
              else begin
                out_value <= 16'($signed(best));
                occ <= occ - CNT_W'(1); out_count <= 5'(occ - CNT_W'(1));
              end
            end
            FN_TRIM_FRONT, FN_TRIM_BACK: begin
              if (occ == '0) out_status <= ST_EMPTY;
              else begin
                out_value <= 16'($signed(best));
                if (func == FN_TRIM_FRONT) begin
                  front <= slot_of(front, best_i);
                  occ <= occ - best_i; out_count <= 5'(occ - best_i);
                end else begin
                  occ <= best_i + CNT_W'(1); out_count <= 5'(best_i + CNT_W'(1));
                end
              end
            end
            FN_SWAP: if (occ < CNT_W'(2)) out_status <= ST_EMPTY;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

/* sv/deque_with_key_delete_and_min_trim.sv */
`default_nettype none
// Push, pop, clear and unused codes answer in the cycle after the item is taken.
// Key delete and trims walk the store, one stored entry per memory read; a delete hit
// closes the gap instead of scanning on. Swap ends reads the back entry, then writes both
// ends. One item at a time; the next item is taken once the result register is empty.
// Reset (rst, synchronous): queue empty, front slot zero; store contents are not cleared.
module deque_with_key_delete_and_min_trim (
  input wire logic clk,
  input wire logic rst,
  dqk_in_if.sink   in_ch,
  dqk_out_if.source out_ch
);
  import dqk_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // sequencer: steps each item, walking the store for search, gap closing and swap
  dqk_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .sts(sts), .ctl(ctl)
  );

  // store, pointers and result register
  dqk_dp u_dp (
    .clk(clk), .rst(rst),
    .in_func(in_ch.func), .in_operand(in_ch.operand),
    .ctl(ctl), .sts(sts),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_status(out_ch.status), .out_value(out_ch.result_value),
    .out_count(out_ch.entry_count)
  );
endmodule
`default_nettype wire
